// ===== sv/tcgp_pkg.sv =====
`timescale 1ns / 1ps
package tcgp_pkg;

	localparam int ADDR_W   = 24;
	localparam int CODE_W   = 8;
	localparam int LINE_AW  = 4;
	localparam int FONT_AW  = LINE_AW + CODE_W;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;

	localparam int DEF_TEXT_COLUMNS = 80;
	localparam int DEF_TEXT_ROWS    = 25;
	localparam int DEF_GLYPH_LINES  = 16;

	localparam logic OPC_CHAR = 1'b0;
	localparam logic OPC_FONT = 1'b1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	localparam logic [CODE_W-1:0] CH_BS    = 8'd8;
	localparam logic [CODE_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CODE_W-1:0] CH_CR    = 8'd13;
	localparam logic [CODE_W-1:0] PRINT_LO = 8'd32;
	localparam logic [CODE_W-1:0] PRINT_HI = 8'd126;
	localparam logic [CODE_W-1:0] TAB_STEP = 8'd8;

	localparam logic [7:0] FILL_ON  = 8'hFF;
	localparam logic [7:0] FILL_OFF = 8'h00;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ERASE,
		ST_BACK,
		ST_GLYPH,
		ST_MOVE,
		ST_CELL,
		ST_SCROLL,
		ST_CURSOR
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BS,
		OP_CR,
		OP_TAB,
		OP_PRINT
	} op_t;

	typedef struct packed {
		logic load;
		logic step;
	} addr_ctl_t;

endpackage

// ===== sv/tcgp_font_mem.sv =====
`timescale 1ns / 1ps
module tcgp_font_mem import tcgp_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [FONT_AW-1:0] waddr,
	input  logic [7:0]         wdata,
	input  logic [FONT_AW-1:0] raddr,
	output logic [7:0]         rdata
);

	localparam int DEPTH = 1 << FONT_AW;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tcgp_addr_unit.sv =====
`timescale 1ns / 1ps
module tcgp_addr_unit import tcgp_pkg::*; #(
	parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS
) (
	input  logic              clk,
	input  addr_ctl_t         ctl,
	input  logic [ADDR_W-1:0] frame_base,
	input  logic [ADDR_W-1:0] cell_off,
	output logic [ADDR_W-1:0] addr
);

	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] opa;
	logic [ADDR_W-1:0] opb;
	logic [ADDR_W-1:0] sum;

	// one adder: start of a cell, then one scanline further per write
	always_comb begin
		opa = ctl.load ? frame_base : addr_q;
		opb = ctl.load ? cell_off : ADDR_W'(TEXT_COLUMNS);
		sum = opa + opb;
	end

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			addr_q <= sum;
		end
	end

	assign addr = addr_q;

endmodule

// ===== sv/tcgp_seq.sv =====
`timescale 1ns / 1ps
module tcgp_seq import tcgp_pkg::*; #(
	parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
	parameter int TEXT_ROWS    = DEF_TEXT_ROWS,
	parameter int GLYPH_LINES  = DEF_GLYPH_LINES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic [CODE_W-1:0]  char_code,
	output logic               font_we,
	output logic [FONT_AW-1:0] font_raddr,
	input  logic [7:0]         font_rdata,
	input  logic [ADDR_W-1:0]  frame_base,
	input  logic [ADDR_W-1:0]  addr,
	output addr_ctl_t          addr_ctl,
	output logic [ADDR_W-1:0]  cell_off,
	input  logic               result_stall,
	output logic               result_valid,
	output logic               kind,
	output logic [ADDR_W-1:0]  address,
	output logic [7:0]         data,
	output logic               last
);

	localparam int LINE_W    = $clog2(GLYPH_LINES);
	localparam int ROW_BYTES = GLYPH_LINES * TEXT_COLUMNS;
	localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(GLYPH_LINES - 1);

	state_t state_q, state_d;
	state_t target_q, target_d;
	op_t    op_q, op_d;

	logic [CODE_W-1:0] ch_q;
	logic [LINE_W-1:0] line_q, line_d;
	logic [ROW_W-1:0]  cursor_row_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic              scroll_q;
	logic [ADDR_W-1:0] cell_q;

	logic [COL_W:0]    col_n;
	logic [COL_W:0]    col_w;
	logic [ROW_W:0]    row_n;
	logic [ROW_W:0]    row_w;
	logic [ROW_W-1:0]  row_f;
	logic              scroll_n;

	logic              accept;
	logic              emit_state;
	logic              slot_free;
	logic              emit;
	logic              line_end;
	logic              emit_kind;
	logic [ADDR_W-1:0] emit_addr;
	logic [7:0]        emit_data;
	logic              emit_last;

	logic              res_valid_q;
	logic              res_kind_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [7:0]        res_data_q;
	logic              res_last_q;

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);
	assign slot_free  = !res_valid_q || !result_stall;
	assign emit_state = (state_q == ST_ERASE) || (state_q == ST_BACK) ||
			(state_q == ST_GLYPH) || (state_q == ST_SCROLL) || (state_q == ST_CURSOR);
	assign emit       = emit_state && slot_free;
	assign line_end   = (line_q == LINE_LAST);

	// classify the character against the cursor as it stands at the request
	always_comb begin
		op_d = OP_NONE;
		priority if (char_code == CH_BS && cursor_col_q != '0) begin
			op_d = OP_BS;
		end else if (char_code == CH_CR) begin
			op_d = OP_CR;
		end else if (char_code == CH_TAB) begin
			op_d = OP_TAB;
		end else if (char_code >= PRINT_LO && char_code <= PRINT_HI) begin
			op_d = OP_PRINT;
		end else begin
			op_d = OP_NONE;
		end
	end

	// new cursor position: step, wrap the column, clamp the row on scroll
	always_comb begin
		row_n = {1'b0, cursor_row_q};
		unique case (op_q)
			OP_BS:    col_n = {1'b0, cursor_col_q} - (COL_W+1)'(1);
			OP_CR: begin
				col_n = '0;
				row_n = {1'b0, cursor_row_q} + (ROW_W+1)'(1);
			end
			OP_TAB:   col_n = {1'b0, cursor_col_q} + (COL_W+1)'(TAB_STEP);
			OP_PRINT: col_n = {1'b0, cursor_col_q} + (COL_W+1)'(1);
			default:  col_n = {1'b0, cursor_col_q};
		endcase
		if (col_n >= (COL_W+1)'(TEXT_COLUMNS)) begin
			col_w = col_n - (COL_W+1)'(TEXT_COLUMNS);
			row_w = row_n + (ROW_W+1)'(1);
		end else begin
			col_w = col_n;
			row_w = row_n;
		end
		scroll_n = (row_w >= (ROW_W+1)'(TEXT_ROWS));
		row_f    = scroll_n ? ROW_W'(TEXT_ROWS - 1) : row_w[ROW_W-1:0];
	end

	// next state
	always_comb begin
		state_d  = state_q;
		target_d = target_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OPC_CHAR) begin
					state_d = ST_LOAD;
					if (op_d == OP_PRINT) begin
						target_d = ST_GLYPH;
					end else if (op_d == OP_NONE) begin
						target_d = ST_CURSOR;
					end else begin
						target_d = ST_ERASE;
					end
				end
			end
			ST_LOAD: state_d = target_q;
			ST_ERASE, ST_GLYPH: begin
				if (emit && line_end) begin
					state_d = ST_MOVE;
				end
			end
			ST_MOVE: state_d = ST_CELL;
			ST_CELL: begin
				state_d  = scroll_q ? ST_SCROLL : ST_LOAD;
				target_d = (op_q == OP_BS) ? ST_BACK : ST_CURSOR;
			end
			ST_SCROLL: begin
				if (emit) begin
					state_d = ST_LOAD;
				end
			end
			ST_BACK: begin
				if (emit && line_end) begin
					state_d  = ST_LOAD;
					target_d = ST_CURSOR;
				end
			end
			ST_CURSOR: begin
				if (emit && line_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		addr_ctl.load = (state_q == ST_LOAD);
		addr_ctl.step = emit && (state_q != ST_SCROLL);
		if (addr_ctl.step) begin
			line_d = line_end ? '0 : line_q + LINE_W'(1);
		end else begin
			line_d = line_q;
		end
		// read ahead so the font byte of the current line is ready
		font_raddr = {LINE_AW'(line_d), ch_q};
		font_we    = accept && (opcode == OPC_FONT);
		emit_kind  = (state_q == ST_SCROLL) ? KIND_SCROLL : KIND_WRITE;
		emit_addr  = (state_q == ST_SCROLL) ? frame_base : addr;
		unique case (state_q)
			ST_ERASE:  emit_data = FILL_OFF;
			ST_SCROLL: emit_data = FILL_OFF;
			ST_GLYPH:  emit_data = font_rdata;
			default:   emit_data = FILL_ON;
		endcase
		emit_last = (state_q == ST_CURSOR) && line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			target_q     <= ST_IDLE;
			op_q         <= OP_NONE;
			line_q       <= '0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			scroll_q     <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			target_q <= target_d;
			line_q   <= line_d;
			if (accept && opcode == OPC_CHAR) begin
				op_q <= op_d;
			end
			if (state_q == ST_MOVE) begin
				cursor_row_q <= row_f;
				cursor_col_q <= col_w[COL_W-1:0];
				scroll_q     <= scroll_n;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= char_code;
		end
		cell_q <= ADDR_W'(cursor_row_q) * ADDR_W'(ROW_BYTES) + ADDR_W'(cursor_col_q);
		if (emit) begin
			res_kind_q <= emit_kind;
			res_addr_q <= emit_addr;
			res_data_q <= emit_data;
			res_last_q <= emit_last;
		end
	end

	assign cell_off     = cell_q;
	assign result_valid = res_valid_q;
	assign kind         = res_kind_q;
	assign address      = res_addr_q;
	assign data         = res_data_q;
	assign last         = res_last_q;

	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cursor_row_q) < TEXT_ROWS) && (32'(cursor_col_q) < TEXT_COLUMNS))
		else $error("cursor left the text grid");

	a_line_rest: assert property (@(posedge clk) disable iff (!arst_n)
		!emit_state |-> (line_q == '0))
		else $error("scanline counter not at zero between phases");

	a_scroll_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == KIND_SCROLL) |-> !res_last_q)
		else $error("scroll command marked as final result");

	a_load_before_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CURSOR && line_q == '0) |-> $past(state_q) == ST_LOAD ||
			$past(state_q) == ST_CURSOR)
		else $error("cursor phase entered without address load");

endmodule

// ===== sv/text_console_glyph_plotter_top.sv =====
`timescale 1ns / 1ps
// channel    handshake                       payload
// config     frame_base_we                   frame_base_wdata
// request    item_valid / item_stall         opcode, char_code, font_index, font_value
// result     result_valid / result_stall     kind, address, data, last
//
// A font load is written into the font store when taken. A character keeps the sequencer busy
// after it is taken: 16 writes per drawn cell, one per cycle while results are not stalled,
// a load state per cell, the move and cell states for the cursor and, on a scroll, a scroll
// state. Backspace draws three cells. The single address adder steps one scanline per write.
// arst_n clears the cursor to row 0, column 0 and frame_base to 0; the font store is not cleared.
// A stalled result holds the sequencer; requests are taken only while it is idle.
module text_console_glyph_plotter_top import tcgp_pkg::*; #(
	parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
	parameter int TEXT_ROWS    = DEF_TEXT_ROWS,
	parameter int GLYPH_LINES  = DEF_GLYPH_LINES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_base_we,
	input  logic [ADDR_W-1:0]  frame_base_wdata,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic [CODE_W-1:0]  char_code,
	input  logic [FONT_AW-1:0] font_index,
	input  logic [7:0]         font_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               kind,
	output logic [ADDR_W-1:0]  address,
	output logic [7:0]         data,
	output logic               last
);

	logic [ADDR_W-1:0]  frame_base_q;
	logic               font_we;
	logic [FONT_AW-1:0] font_raddr;
	logic [7:0]         font_rdata;
	logic [ADDR_W-1:0]  addr;
	logic [ADDR_W-1:0]  cell_off;
	addr_ctl_t          addr_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
		end else if (frame_base_we) begin
			frame_base_q <= frame_base_wdata;
		end
	end

	tcgp_font_mem u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_index),
		.wdata (font_value),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

	tcgp_addr_unit #(
		.TEXT_COLUMNS (TEXT_COLUMNS)
	) u_addr (
		.clk        (clk),
		.ctl        (addr_ctl),
		.frame_base (frame_base_q),
		.cell_off   (cell_off),
		.addr       (addr)
	);

	tcgp_seq #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.TEXT_ROWS    (TEXT_ROWS),
		.GLYPH_LINES  (GLYPH_LINES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.char_code    (char_code),
		.font_we      (font_we),
		.font_raddr   (font_raddr),
		.font_rdata   (font_rdata),
		.frame_base   (frame_base_q),
		.addr         (addr),
		.addr_ctl     (addr_ctl),
		.cell_off     (cell_off),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.kind         (kind),
		.address      (address),
		.data         (data),
		.last         (last)
	);

endmodule

// ===== tb/sv/tb_text_console_glyph_plotter_top.sv =====
`timescale 1ns / 1ps
module tb_text_console_glyph_plotter_top;
	import tcgp_pkg::*;

	localparam int TEXT_COLUMNS = DEF_TEXT_COLUMNS;
	localparam int TEXT_ROWS    = DEF_TEXT_ROWS;
	localparam int GLYPH_LINES  = DEF_GLYPH_LINES;
	localparam int FONT_DEPTH   = 1 << FONT_AW;
	localparam int PHASE_ITEMS  = 70;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 1500;

	typedef struct packed {
		logic               opcode;
		logic [CODE_W-1:0]  char_code;
		logic [FONT_AW-1:0] font_index;
		logic [7:0]         font_value;
	} request_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] address;
		logic [7:0]        data;
		logic              last;
	} fb_op_t;

	typedef struct packed {
		logic               typed;
		logic               opc;
		logic [CODE_W-1:0]  code;
		logic [FONT_AW-1:0] idx;
		logic [7:0]         val;
		logic [7:0]         n;
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         dat;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               frame_base_we = 1'b0;
	logic [ADDR_W-1:0]  frame_base_wdata = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               opcode = OPC_CHAR;
	logic [CODE_W-1:0]  char_code = '0;
	logic [FONT_AW-1:0] font_index = '0;
	logic [7:0]         font_value = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               kind;
	logic [ADDR_W-1:0]  address;
	logic [7:0]         data;
	logic               last;

	// shadow of the block
	logic [ADDR_W-1:0] fb_base = '0;
	int unsigned       cur_row = 0;
	int unsigned       cur_col = 0;
	logic [7:0]        glyph_mem [FONT_DEPTH];
	bit                glyph_set [FONT_DEPTH];

	fb_op_t fb_ops_due[$];
	bit     offering = 1'b0;
	int     burst_left = 1;
	int     fails = 0;
	int     requests_sent = 0;
	int     font_loads = 0;
	int     results_taken = 0;
	int     scrolls_due = 0;
	int     base_settings = 0;

	dir_row_t dir_rows [24];

	text_console_glyph_plotter_top #(
		.TEXT_COLUMNS(TEXT_COLUMNS),
		.TEXT_ROWS   (TEXT_ROWS),
		.GLYPH_LINES (GLYPH_LINES)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_base_we   (frame_base_we),
		.frame_base_wdata(frame_base_wdata),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.opcode          (opcode),
		.char_code       (char_code),
		.font_index      (font_index),
		.font_value      (font_value),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.kind            (kind),
		.address         (address),
		.data            (data),
		.last            (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] cell_address(input int unsigned r,
			input int unsigned c, input int unsigned i);
		return ADDR_W'(fb_base + c + r * GLYPH_LINES * TEXT_COLUMNS + i * TEXT_COLUMNS);
	endfunction

	function automatic bit glyph_ready(input logic [CODE_W-1:0] code);
		for (int i = 0; i < GLYPH_LINES; i++)
			if (!glyph_set[FONT_AW'((i << CODE_W) + code)])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic push_op(input logic k, input logic [ADDR_W-1:0] a, input logic [7:0] d);
		fb_op_t op;
		op.kind = k;
		op.address = a;
		op.data = d;
		op.last = 1'b0;
		fb_ops_due.push_back(op);
	endtask

	task automatic plot_cell(input int unsigned r, input int unsigned c, input logic [7:0] fill);
		for (int i = 0; i < GLYPH_LINES; i++)
			push_op(KIND_WRITE, cell_address(r, c, i), fill);
	endtask

	task automatic render_request(input request_t rq);
		int unsigned r;
		int unsigned c;
		r = cur_row;
		c = cur_col;
		if (rq.opcode == OPC_FONT) begin
			glyph_mem[rq.font_index] = rq.font_value;
			glyph_set[rq.font_index] = 1'b1;
			return;
		end
		if (rq.char_code == CH_BS && c > 0) begin
			plot_cell(r, c, FILL_OFF);
			c--;
			plot_cell(r, c, FILL_ON);
		end else if (rq.char_code == CH_CR) begin
			plot_cell(r, c, FILL_OFF);
			r++;
			c = 0;
		end else if (rq.char_code == CH_TAB) begin
			plot_cell(r, c, FILL_OFF);
			c += TAB_STEP;
		end else if (rq.char_code >= PRINT_LO && rq.char_code <= PRINT_HI) begin
			for (int i = 0; i < GLYPH_LINES; i++)
				push_op(KIND_WRITE, cell_address(r, c, i),
					glyph_mem[FONT_AW'((i << CODE_W) + rq.char_code)]);
			c++;
		end
		if (c >= TEXT_COLUMNS) begin
			r++;
			c = c % TEXT_COLUMNS;
		end
		if (r >= TEXT_ROWS) begin
			push_op(KIND_SCROLL, fb_base, FILL_OFF);
			r = TEXT_ROWS - 1;
			scrolls_due++;
		end
		plot_cell(r, c, FILL_ON);
		fb_ops_due[fb_ops_due.size() - 1].last = 1'b1;
		cur_row = r;
		cur_col = c;
	endtask

	// offer one request and hold it until taken; valid stays up for the next one
	task automatic send_request(input request_t rq, output int n_new, output fb_op_t head);
		int sz;
		item_valid <= 1'b1;
		offering = 1'b1;
		opcode <= rq.opcode;
		char_code <= rq.char_code;
		font_index <= rq.font_index;
		font_value <= rq.font_value;
		do @(posedge clk); while (item_stall);
		sz = fb_ops_due.size();
		render_request(rq);
		n_new = fb_ops_due.size() - sz;
		head = (n_new > 0) ? fb_ops_due[sz] : '0;
		requests_sent++;
		if (rq.opcode == OPC_FONT)
			font_loads++;
	endtask

	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 5) != 0) begin
				item_valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic settle();
		if (offering) begin
			item_valid <= 1'b0;
			offering = 1'b0;
		end
		while (fb_ops_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame_base(input logic [ADDR_W-1:0] v);
		settle();
		frame_base_we <= 1'b1;
		frame_base_wdata <= v;
		@(posedge clk);
		fb_base = v;
		base_settings++;
		frame_base_we <= 1'b0;
		frame_base_wdata <= ADDR_W'($urandom);
	endtask

	task automatic load_glyph(input logic [CODE_W-1:0] code, input bit fixed,
			input logic [7:0] fill);
		request_t rq;
		int n_new;
		fb_op_t head;
		for (int i = 0; i < GLYPH_LINES; i++) begin
			rq.opcode = OPC_FONT;
			rq.char_code = CODE_W'($urandom);
			rq.font_index = FONT_AW'((i << CODE_W) + code);
			rq.font_value = fixed ? fill : 8'($urandom);
			send_request(rq, n_new, head);
			pace();
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	// result side: check and stall pattern
	initial begin : result_side
		fb_op_t want;
		int mode;
		int mode_left;
		int hold_left;
		bit hold_done;
		logic nxt;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				results_taken++;
				if (fb_ops_due.size() == 0) begin
					$error("result with nothing expected: kind %0d address 0x%0h data 0x%0h",
						kind, address, data);
					fails++;
				end else begin
					want = fb_ops_due.pop_front();
					check_field("kind", want.kind, kind);
					check_field("address", want.address, address);
					check_field("data", want.data, data);
					check_field("last", want.last, last);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else if (!hold_done && results_taken >= HOLD_AFTER) begin
				// back up the block so it stalls its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				nxt = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				case (mode)
					0: nxt = 1'b0;
					1: nxt = ($urandom_range(0, 3) == 0);
					default: nxt = ($urandom_range(0, 3) != 0);
				endcase
			end
			result_stall <= nxt;
		end
	end

	initial begin : request_side
		request_t rq;
		int n_new;
		fb_op_t head;
		int pick;
		int phase_start;
		logic [CODE_W-1:0] ready_codes[$];
		logic [CODE_W-1:0] code;
		logic [ADDR_W-1:0] bases [4];

		dir_rows = '{
			'{1'b1, OPC_CHAR, 8'd0,     12'd0,    8'd0,  8'd16, 24'd0,    FILL_ON},
			'{1'b1, OPC_CHAR, 8'd255,   12'd4095, 8'd255, 8'd16, 24'd0,   FILL_ON},
			'{1'b1, OPC_CHAR, CH_BS,    12'd0,    8'd0,  8'd16, 24'd0,    FILL_ON},
			'{1'b1, OPC_CHAR, PRINT_HI, 12'd0,    8'd0,  8'd32, 24'd0,    FILL_ON},
			'{1'b1, OPC_CHAR, PRINT_LO, 12'd0,    8'd0,  8'd32, 24'd1,    FILL_OFF},
			'{1'b1, OPC_CHAR, CH_BS,    12'd0,    8'd0,  8'd48, 24'd2,    FILL_OFF},
			'{1'b1, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd32, 24'd1,    FILL_OFF},
			'{1'b1, OPC_CHAR, CH_CR,    12'd0,    8'd0,  8'd32, 24'd9,    FILL_OFF},
			'{1'b1, OPC_CHAR, 8'd127,   12'd0,    8'd0,  8'd16, 24'd1280, FILL_ON},
			'{1'b1, OPC_CHAR, 8'd31,    12'd0,    8'd0,  8'd16, 24'd1280, FILL_ON},
			'{1'b1, OPC_FONT, 8'd255,   12'd4095, 8'hA5, 8'd0,  24'd0,    FILL_OFF},
			'{1'b1, OPC_FONT, 8'd0,     12'd0,    8'h5A, 8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, 8'd10,    12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			'{1'b0, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF},
			// tab from the last stop wraps to the next row
			'{1'b1, OPC_CHAR, CH_TAB,   12'd0,    8'd0,  8'd32, 24'd1352, FILL_OFF},
			'{1'b0, OPC_CHAR, PRINT_HI, 12'd0,    8'd0,  8'd0,  24'd0,    FILL_OFF}
		};
		bases = '{24'hFFFFFF, ADDR_W'($urandom), 24'h000000,
			ADDR_W'($urandom_range(24'hFFC000, 24'hFFFFFF))};
		foreach (glyph_set[k])
			glyph_set[k] = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_glyph(PRINT_HI, 1'b1, FILL_ON);
		load_glyph(PRINT_LO, 1'b1, FILL_OFF);

		foreach (dir_rows[k]) begin
			rq.opcode = dir_rows[k].opc;
			rq.char_code = dir_rows[k].code;
			rq.font_index = dir_rows[k].idx;
			rq.font_value = dir_rows[k].val;
			send_request(rq, n_new, head);
			if (dir_rows[k].typed) begin
				check_field("result count", dir_rows[k].n, unsigned'(n_new));
				if (n_new > 0) begin
					check_field("first address", dir_rows[k].addr, head.address);
					check_field("first data", dir_rows[k].dat, head.data);
				end
			end
			pace();
		end

		foreach (bases[p]) begin
			set_frame_base(bases[p]);
			phase_start = requests_sent;
			while (requests_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					load_glyph(CODE_W'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0, FILL_OFF);
					continue;
				end
				rq.font_index = FONT_AW'($urandom);
				rq.font_value = 8'($urandom);
				rq.char_code = CODE_W'($urandom);
				if (pick < 16) begin
					rq.opcode = OPC_FONT;
				end else begin
					rq.opcode = OPC_CHAR;
					pick = $urandom_range(0, 99);
					if (pick < 12) begin
						rq.char_code = CH_BS;
					end else if (pick < 28) begin
						rq.char_code = CH_CR;
					end else if (pick < 38) begin
						rq.char_code = CH_TAB;
					end else if (pick < 43) begin
						// control or high code with no action of its own
						do code = CODE_W'($urandom);
						while (code == CH_BS || code == CH_TAB || code == CH_CR ||
							(code >= PRINT_LO && code <= PRINT_HI));
						rq.char_code = code;
					end else begin
						ready_codes.delete();
						for (int c = PRINT_LO; c <= PRINT_HI; c++)
							if (glyph_ready(CODE_W'(c)))
								ready_codes.push_back(CODE_W'(c));
						rq.char_code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
					end
				end
				send_request(rq, n_new, head);
				pace();
			end
		end

		settle();
		$display("Ran %0d requests (%0d font loads) over %0d frame_base settings;",
			requests_sent, font_loads, base_settings);
		$display("checked %0d framebuffer results including %0d scrolls.",
			results_taken, scrolls_due);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
